>>> rtl/rles_pkg.sv
// shared constants, codes and types for the row lane edge scan block
// no dependencies; imported by rles_ratio_cmp and row_lane_edge_scan
`timescale 1ns / 1ps

package rles_pkg;

   // image geometry and pair spacing
   localparam int ROWS     = 120;
   localparam int COLS     = 188;
   localparam int PAIR_GAP = 5;
   localparam int CENTER   = (COLS - 1) / 2;

   // field widths
   localparam int ROW_W = 7;
   localparam int COL_W = 8;
   localparam int PIX_W = 8;
   localparam int THR_W = 8;

   // frame store geometry
   localparam int FRAME_DEPTH = ROWS * COLS;
   localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

   // item modes
   localparam logic [1:0] MODE_PIXEL = 2'd0;
   localparam logic [1:0] MODE_WIDTH = 2'd1;
   localparam logic [1:0] MODE_SCAN  = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_THR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_THR  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RIGHT,
      ST_LEFT,
      ST_MIDDLE,
      ST_RESULT
   } state_type;

endpackage

>>> rtl/rles_ratio_cmp.sv
// shared contrast ratio compare: 100*(a-b) < thr*(a+b), exact over the integers
// depends on rles_pkg for pixel and threshold widths
`timescale 1ns / 1ps

module rles_ratio_cmp import rles_pkg::*; (
   input  logic [PIX_W-1:0]        pix_a,
   input  logic [PIX_W-1:0]        pix_b,
   input  logic signed [THR_W-1:0] thr,
   output logic                    below
);

   logic signed [PIX_W+1:0]  diff;
   logic [PIX_W:0]           sum;
   logic signed [PIX_W+8:0]  lhs;
   logic signed [PIX_W+9:0]  rhs;

   always_comb begin
      diff  = $signed({2'b00, pix_a}) - $signed({2'b00, pix_b});
      sum   = {1'b0, pix_a} + {1'b0, pix_b};
      lhs   = (PIX_W+9)'(diff) * (PIX_W+9)'(100);
      rhs   = (PIX_W+10)'(thr) * $signed({9'b0, sum});
      // a zero sum gives 0 < 0, so it never matches
      below = (PIX_W+10)'(lhs) < rhs;
   end

endmodule

>>> rtl/row_lane_edge_scan.sv
// row lane edge scan: a pixel or width write is accepted while idle, one write per cycle
// a row scan handles each column as four reads on the one frame store port and then
// the pair decision, over at most 189 columns in both walks, then a middle step; the result
// is held until taken, and no new item is accepted before then
// reset: idle, start column and previous middle at the image center, thresholds
// at 0; frame store and width table are not cleared and need no clearing pass
`timescale 1ns / 1ps

module row_lane_edge_scan import rles_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // item input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [ROW_W-1:0]     req_row,
   input  logic [COL_W-1:0]     req_col,
   input  logic [PIX_W-1:0]     req_value,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ROW_W-1:0]     rsp_scanned_row,
   output logic [COL_W-1:0]     rsp_left_edge,
   output logic [COL_W-1:0]     rsp_right_edge,
   output logic [COL_W-1:0]     rsp_middle,
   // register writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_wdata
);

   // column phases: four pixel reads, then the pair decision
   localparam logic [2:0] PH_A1   = 3'd0;
   localparam logic [2:0] PH_B1   = 3'd1;
   localparam logic [2:0] PH_A2   = 3'd2;
   localparam logic [2:0] PH_B2   = 3'd3;
   localparam logic [2:0] PH_EVAL = 3'd4;

   localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLS - 1);
   localparam logic [COL_W-1:0] COL_CENTER = COL_W'(CENTER);
   localparam logic [COL_W-1:0] RIGHT_MIN  = COL_W'(PAIR_GAP + 1);
   localparam logic [COL_W-1:0] LEFT_MAX   = COL_W'(COLS - 2 - PAIR_GAP);

   function automatic logic [COL_W-1:0] sat_col(input logic signed [COL_W+2:0] v);
      logic [COL_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > COLS - 2) begin
         res = COL_LAST;
      end else begin
         res = v[COL_W-1:0];
      end
      return res;
   endfunction

   // control and sequencer state
   state_type          state_ff, state_in;
   logic [2:0]         phase_ff, phase_in;
   logic [COL_W-1:0]   x_ff, x_in;
   logic [COL_W-1:0]   start_ff, start_in;
   logic [COL_W-1:0]   prev_ff, prev_in;
   logic [THR_W-1:0]   rthr_ff, rthr_in;
   logic [THR_W-1:0]   lthr_ff, lthr_in;

   // scan payload
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [FRAME_AW-1:0] row_base_ff, row_base_in;
   logic [PIX_W-1:0]    a_ff, a_in;
   logic                m1_ff, m1_in;
   logic [COL_W-1:0]    left_ff, left_in;
   logic [COL_W-1:0]    right_ff, right_in;
   logic [COL_W-1:0]    middle_ff, middle_in;

   // memories and their registered read data
   logic [PIX_W-1:0]    frame_mem [FRAME_DEPTH];
   logic [PIX_W-1:0]    hw_mem [ROWS];
   logic [PIX_W-1:0]    pix_rd_ff;
   logic [PIX_W-1:0]    hw_rd_ff;

   logic                req_fire;
   logic                pix_we;
   logic                hw_we;
   logic                going_right;
   logic                in_range;
   logic signed [COL_W+1:0] col_off;
   logic signed [COL_W+1:0] col_s;
   logic [COL_W-1:0]    rd_col;
   logic [FRAME_AW-1:0] rd_addr;
   logic [FRAME_AW-1:0] wr_addr;
   logic signed [THR_W-1:0] cmp_thr;
   logic                cmp_below;
   logic                pair_ok;
   logic signed [COL_W+2:0] mid_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESULT);
   assign req_fire  = req_valid && req_ready;

   // store writes happen at acceptance; out of range writes are dropped
   assign pix_we  = req_fire && (req_mode == MODE_PIXEL)
                    && (req_row < ROW_W'(ROWS)) && (req_col < COL_W'(COLS));
   assign hw_we   = req_fire && (req_mode == MODE_WIDTH) && (req_row < ROW_W'(ROWS));
   assign wr_addr = FRAME_AW'(FRAME_AW'(req_row) * FRAME_AW'(COLS)) + FRAME_AW'(req_col);

   // read address for the pixel of the current phase
   always_comb begin
      going_right = (state_ff == ST_RIGHT);
      in_range    = going_right ? (x_ff >= RIGHT_MIN) : (x_ff <= LEFT_MAX);
      case (phase_ff)
         PH_A1:   col_off = '0;
         PH_B1:   col_off = going_right ? (COL_W+2)'(-PAIR_GAP) : (COL_W+2)'(PAIR_GAP);
         PH_A2:   col_off = going_right ? (COL_W+2)'(-1) : (COL_W+2)'(1);
         PH_B2:   col_off = going_right ? (COL_W+2)'(-1 - PAIR_GAP)
                                        : (COL_W+2)'(1 + PAIR_GAP);
         default: col_off = '0;
      endcase
      col_s   = $signed({2'b00, x_ff}) + col_off;
      // columns outside the image are never used; park the address on the row
      rd_col  = in_range ? col_s[COL_W-1:0] : '0;
      rd_addr = row_base_ff + FRAME_AW'(rd_col);
      cmp_thr = going_right ? $signed(rthr_ff) : $signed(lthr_ff);
   end

   // the one shared compare unit, used twice per column
   rles_ratio_cmp u_cmp (
      .pix_a (a_ff),
      .pix_b (pix_rd_ff),
      .thr   (cmp_thr),
      .below (cmp_below)
   );

   assign pair_ok = in_range && m1_ff && cmp_below;

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pix_we) begin
         frame_mem[wr_addr] <= req_value;
      end
      pix_rd_ff <= frame_mem[rd_addr];
   end

   // half width table, read at the scanned row
   always_ff @(posedge clock) begin
      if (hw_we) begin
         hw_mem[req_row] <= req_value;
      end
      hw_rd_ff <= hw_mem[row_ff];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      x_in        = x_ff;
      start_in    = start_ff;
      prev_in     = prev_ff;
      row_in      = row_ff;
      row_base_in = row_base_ff;
      a_in        = a_ff;
      m1_in       = m1_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      middle_in   = middle_ff;
      mid_sum     = '0;

      rthr_in = (csr_wr_en && csr_index == CSR_RIGHT_THR) ? csr_wdata : rthr_ff;
      lthr_in = (csr_wr_en && csr_index == CSR_LEFT_THR) ? csr_wdata : lthr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_mode == MODE_SCAN && req_row < ROW_W'(ROWS)) begin
               row_in      = req_row;
               row_base_in = FRAME_AW'(FRAME_AW'(req_row) * FRAME_AW'(COLS));
               right_in    = COL_LAST;
               left_in     = '0;
               phase_in    = PH_A1;
               state_in    = ST_RIGHT;
               // bottom row restarts from the image center
               if (req_row == ROW_W'(ROWS - 1)) begin
                  start_in = COL_CENTER;
                  prev_in  = COL_CENTER;
                  x_in     = COL_CENTER;
               end else begin
                  x_in = start_ff;
               end
            end
         end
         ST_RIGHT, ST_LEFT: begin
            case (phase_ff)
               PH_A1: begin
                  phase_in = PH_B1;
               end
               PH_B1: begin
                  a_in     = pix_rd_ff;
                  phase_in = PH_A2;
               end
               PH_A2: begin
                  m1_in    = cmp_below;
                  phase_in = PH_B2;
               end
               PH_B2: begin
                  a_in     = pix_rd_ff;
                  phase_in = PH_EVAL;
               end
               PH_EVAL: begin
                  phase_in = PH_A1;
                  if (going_right) begin
                     if (pair_ok || x_ff == COL_LAST) begin
                        if (pair_ok) begin
                           right_in = x_ff - COL_W'(2);
                        end
                        state_in = ST_LEFT;
                        x_in     = start_ff;
                     end else begin
                        x_in = x_ff + COL_W'(1);
                     end
                  end else begin
                     if (pair_ok || x_ff == '0) begin
                        if (pair_ok) begin
                           left_in = x_ff + COL_W'(2);
                        end
                        state_in = ST_MIDDLE;
                     end else begin
                        x_in = x_ff - COL_W'(1);
                     end
                  end
               end
               default: begin
                  phase_in = PH_A1;
               end
            endcase
         end
         ST_MIDDLE: begin
            // edge codes: right at the last column or left at 0 mean not found
            if (right_ff == COL_LAST && left_ff == '0) begin
               middle_in = prev_ff;
            end else begin
               if (right_ff == COL_LAST) begin
                  mid_sum = $signed({3'b000, left_ff}) + $signed({3'b000, hw_rd_ff});
               end else if (left_ff == '0) begin
                  mid_sum = $signed({3'b000, right_ff}) - $signed({3'b000, hw_rd_ff});
               end else begin
                  mid_sum = ($signed({3'b000, right_ff}) + $signed({3'b000, left_ff})) >>> 1;
               end
               middle_in = sat_col(mid_sum);
               start_in  = sat_col(mid_sum);
            end
            prev_in  = middle_in;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_A1;
         start_ff <= COL_CENTER;
         prev_ff  <= COL_CENTER;
         rthr_ff  <= '0;
         lthr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         prev_ff  <= prev_in;
         rthr_ff  <= rthr_in;
         lthr_ff  <= lthr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      row_ff      <= row_in;
      row_base_ff <= row_base_in;
      a_ff        <= a_in;
      m1_ff       <= m1_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      middle_ff   <= middle_in;
   end

   assign rsp_scanned_row = row_ff;
   assign rsp_left_edge   = left_ff;
   assign rsp_right_edge  = right_ff;
   assign rsp_middle      = middle_ff;

   // a result blocks new items until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted while a result is pending");

   // a taken result returns the block to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("block not idle after result handoff");

   // the column sequencer never leaves its five phases
   assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_EVAL)
      else $error("column phase out of range");

   // start column and middle stay inside the image
   assert property (@(posedge clock) disable iff (reset)
      (start_ff <= COL_LAST) && (prev_ff <= COL_LAST))
      else $error("start column or previous middle outside image");

   // a found right edge sits at least two columns left of the image border
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_edge == COL_LAST || rsp_right_edge <= COL_LAST - COL_W'(2)))
      else $error("right edge code inconsistent");

endmodule
